FILE: sv/firmware_download_receiver_unit_defines.svh
// ---------------------------------------------------------------------------
// firmware download receiver: assertion macros
// concurrent checks, empty when built for synthesis
// ---------------------------------------------------------------------------
`ifndef FIRMWARE_DOWNLOAD_RECEIVER_UNIT_DEFINES_SVH
`define FIRMWARE_DOWNLOAD_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FDR_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FDR_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define FDR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/fdr_pkg.sv
// ---------------------------------------------------------------------------
// fdr_pkg
// shared types, codes and the byte-wide crc-32 update
// ---------------------------------------------------------------------------
package fdr_pkg;

    localparam int FDR_QUEUE_DEPTH = 4;

    localparam int FDR_S_TDATA_W = 168;
    localparam int FDR_S_TUSER_W = 2;
    localparam int FDR_M_TDATA_W = 112;
    localparam int FDR_CFG_ADDR_W = 2;
    localparam int FDR_CFG_DATA_W = 32;

    localparam logic [31:0] FDR_MAGIC_WORD = 32'h4657_504B;
    localparam logic [31:0] FDR_CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] FDR_CRC_INIT   = 32'hFFFF_FFFF;

    // item kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CHUNK  = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_VERIFY = 2'd3;

    // receiver modes
    localparam logic [1:0] MODE_IDLE        = 2'd0;
    localparam logic [1:0] MODE_DOWNLOADING = 2'd1;
    localparam logic [1:0] MODE_READY       = 2'd2;
    localparam logic [1:0] MODE_ERROR       = 2'd3;

    // register indexes
    localparam logic [1:0] CFG_DEV_ID      = 2'd0;
    localparam logic [1:0] CFG_BACKUP_BASE = 2'd1;
    localparam logic [1:0] CFG_BACKUP_SIZE = 2'd2;

    localparam logic [15:0] CFG_DEV_ID_RST      = 16'h0001;
    localparam logic [31:0] CFG_BACKUP_BASE_RST = 32'h0803_8000;
    localparam logic [31:0] CFG_BACKUP_SIZE_RST = 32'd1024;

    // input transfer payload, first member in the highest bits
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] chunk_length;
        logic [31:0] chunk_offset;
        logic [31:0] hdr_checksum;
        logic [31:0] header_image_size;
        logic [15:0] header_device;
        logic [31:0] header_magic;
    } in_fields_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  kind;
        logic        header_ok;
        logic [31:0] image_size;
        logic [31:0] hdr_checksum;
        logic [32:0] chunk_end;
        logic        area_ok;
        logic [15:0] chunk_length;
        logic [31:0] chunk_address;
        logic [7:0]  data_byte;
    } cmd_t;

    // result transfer payload, status in the lowest bits
    typedef struct packed {
        logic [31:0] computed_crc;
        logic [31:0] received_count;
        logic [7:0]  flash_data;
        logic [31:0] flash_address;
        logic        flash_write;
        logic        erase_request;
        logic        accepted;
        logic [1:0]  status;
    } res_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] fdr_crc_byte(input logic [31:0] crc,
                                                 input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ FDR_CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/firmware_download_receiver_unit.sv
// ---------------------------------------------------------------------------
// firmware_download_receiver_unit
// firmware image receiver with crc-32 check and flash write generation
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   s_tdata (image fields), s_tuser (kind)
//   m_       out  m_tvalid/m_tready   m_tdata (result fields)
//   cfg_     in   cfg_we              cfg_addr, cfg_wdata
//
// one item per cycle sustained while m_tready is high; a result is presented after its
// input transfer passes the queue write and then the result register
// the back end state update with its byte-wide crc network sets the rate
// reset: synchronous, active low, no clearing pass
// the queue lets the input keep taking transfers while m_tready is low
// until QUEUE_DEPTH commands are waiting
// ---------------------------------------------------------------------------
module firmware_download_receiver_unit
    import fdr_pkg::*;
#(
    parameter int QUEUE_DEPTH = FDR_QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // header_magic, header_device, header_image_size, hdr_checksum,
    // chunk_offset, chunk_length, data_byte
    input  logic [FDR_S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [FDR_S_TUSER_W-1:0]  s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status, accepted, erase_request, flash_write, flash_address,
    // flash_data, received_count, computed_crc, zero padding
    output logic [FDR_M_TDATA_W-1:0]  m_tdata,
    input  logic                      cfg_we,
    input  logic [FDR_CFG_ADDR_W-1:0] cfg_addr,
    input  logic [FDR_CFG_DATA_W-1:0] cfg_wdata
);

    logic [15:0] dev_id_reg;
    logic [31:0] backup_base_reg;
    logic [31:0] backup_size_reg;

    logic push;
    logic push_ready;
    cmd_t push_cmd;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_id_reg      <= CFG_DEV_ID_RST;
            backup_base_reg <= CFG_BACKUP_BASE_RST;
            backup_size_reg <= CFG_BACKUP_SIZE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DEV_ID:      dev_id_reg      <= cfg_wdata[15:0];
                CFG_BACKUP_BASE: backup_base_reg <= cfg_wdata;
                CFG_BACKUP_SIZE: backup_size_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    fdr_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .dev_id      (dev_id_reg),
        .backup_base (backup_base_reg),
        .backup_size (backup_size_reg),
        .queue_ready (push_ready),
        .push_valid  (push),
        .push_cmd    (push_cmd)
    );

    fdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    fdr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: sv/fdr_front.sv
// ---------------------------------------------------------------------------
// fdr_front
// accepts input transfers, checks the header and chunk window bounds
// against the configuration and builds a command for the queue
// ---------------------------------------------------------------------------
module fdr_front
    import fdr_pkg::*;
(
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [FDR_S_TDATA_W-1:0] s_tdata,
    input  logic [FDR_S_TUSER_W-1:0] s_tuser,
    input  logic [15:0]              dev_id,
    input  logic [31:0]              backup_base,
    input  logic [31:0]              backup_size,
    input  logic                     queue_ready,
    output logic                     push_valid,
    output cmd_t                     push_cmd
);

    in_fields_t fields;

    assign fields     = in_fields_t'(s_tdata);
    assign s_tready   = queue_ready;
    assign push_valid = s_tvalid && queue_ready;

    always_comb begin
        push_cmd               = '0;
        push_cmd.kind          = s_tuser;
        push_cmd.header_ok     = (fields.header_magic == FDR_MAGIC_WORD) &&
                                 (fields.header_device == dev_id);
        push_cmd.image_size    = fields.header_image_size;
        push_cmd.hdr_checksum  = fields.hdr_checksum;
        // window end without wrap
        push_cmd.chunk_end     = {1'b0, fields.chunk_offset} + {17'd0, fields.chunk_length};
        push_cmd.area_ok       = (push_cmd.chunk_end <= {1'b0, backup_size});
        push_cmd.chunk_length  = fields.chunk_length;
        push_cmd.chunk_address = backup_base + fields.chunk_offset;
        push_cmd.data_byte     = fields.data_byte;
    end

endmodule

FILE: sv/fdr_queue.sv
// ---------------------------------------------------------------------------
// fdr_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
`include "firmware_download_receiver_unit_defines.svh"

module fdr_queue
    import fdr_pkg::*;
#(
    parameter int DEPTH = FDR_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `FDR_ASSERT_IMPLIES(a_no_push_when_full, aclk, aresetn, push, count_reg != FULL_CNT, "push into full queue")
    `FDR_ASSERT_NEXT(a_count_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow")

endmodule

FILE: sv/fdr_back.sv
// ---------------------------------------------------------------------------
// fdr_back
// download state, crc update and flash write generation, one command per
// cycle into the result register when it is empty or m_tready is high
// ---------------------------------------------------------------------------
`include "firmware_download_receiver_unit_defines.svh"

module fdr_back
    import fdr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output logic                     cmd_pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [FDR_M_TDATA_W-1:0] m_tdata
);

    logic [1:0]  mode_reg, mode_next;
    logic [31:0] image_size_reg, image_size_next;
    logic [31:0] expected_crc_reg, expected_crc_next;
    logic [31:0] byte_total_reg, byte_total_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [31:0] next_addr_reg, next_addr_next;

    logic        m_tvalid_reg;
    res_t        res_reg, res_next;
    logic [31:0] crc_fed;

    // result register frees up as soon as its transfer completes
    assign cmd_pop  = cmd_valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = FDR_M_TDATA_W'(res_reg);
    assign crc_fed  = fdr_crc_byte(crc_reg, cmd.data_byte);

    always_comb begin
        mode_next         = mode_reg;
        image_size_next   = image_size_reg;
        expected_crc_next = expected_crc_reg;
        byte_total_next   = byte_total_reg;
        crc_next          = crc_reg;
        bytes_left_next   = bytes_left_reg;
        next_addr_next    = next_addr_reg;
        res_next          = '0;

        case (cmd.kind)
            KIND_HEADER: begin
                if (cmd.header_ok) begin
                    image_size_next        = cmd.image_size;
                    expected_crc_next      = cmd.hdr_checksum;
                    byte_total_next        = '0;
                    crc_next               = FDR_CRC_INIT;
                    bytes_left_next        = '0;
                    mode_next              = MODE_DOWNLOADING;
                    res_next.erase_request = 1'b1;
                    res_next.accepted      = 1'b1;
                end else begin
                    mode_next = MODE_ERROR;
                end
            end
            KIND_CHUNK: begin
                if (mode_reg == MODE_DOWNLOADING) begin
                    if ((cmd.chunk_end > {1'b0, image_size_reg}) || !cmd.area_ok) begin
                        mode_next       = MODE_ERROR;
                        bytes_left_next = '0;
                    end else begin
                        bytes_left_next   = cmd.chunk_length;
                        next_addr_next    = cmd.chunk_address;
                        res_next.accepted = 1'b1;
                    end
                end
            end
            KIND_DATA: begin
                if ((mode_reg == MODE_DOWNLOADING) && (bytes_left_reg != '0)) begin
                    crc_next               = crc_fed;
                    next_addr_next         = next_addr_reg + 1'b1;
                    bytes_left_next        = bytes_left_reg - 1'b1;
                    byte_total_next        = byte_total_reg + 1'b1;
                    res_next.flash_write   = 1'b1;
                    res_next.flash_address = next_addr_reg;
                    res_next.flash_data    = cmd.data_byte;
                    res_next.accepted      = 1'b1;
                end
            end
            KIND_VERIFY: begin
                if (mode_reg == MODE_DOWNLOADING) begin
                    if (byte_total_reg != image_size_reg) begin
                        mode_next = MODE_ERROR;
                    end else if (~crc_reg != expected_crc_reg) begin
                        mode_next = MODE_ERROR;
                    end else begin
                        mode_next         = MODE_READY;
                        res_next.accepted = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        res_next.status         = mode_next;
        res_next.received_count = byte_total_next;
        res_next.computed_crc   = ~crc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            image_size_reg   <= '0;
            expected_crc_reg <= '0;
            byte_total_reg   <= '0;
            crc_reg          <= FDR_CRC_INIT;
            bytes_left_reg   <= '0;
            next_addr_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cmd_pop) begin
                mode_reg         <= mode_next;
                image_size_reg   <= image_size_next;
                expected_crc_reg <= expected_crc_next;
                byte_total_reg   <= byte_total_next;
                crc_reg          <= crc_next;
                bytes_left_reg   <= bytes_left_next;
                next_addr_reg    <= next_addr_next;
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            res_reg <= res_next;
        end
    end

    `FDR_ASSERT_NEXT(a_write_only_on_data, aclk, aresetn, cmd_pop && (cmd.kind != KIND_DATA), !res_reg.flash_write, "flash write from a non-data item")
    `FDR_ASSERT_IMPLIES(a_erase_starts_download, aclk, aresetn, m_tvalid_reg && res_reg.erase_request, res_reg.status == MODE_DOWNLOADING, "erase without entering download")

endmodule
